>>> rtl/core/cbsel_pkg.sv
// ----------------------------------------------------------------------------
// cbsel_pkg
// Shared types and constants for the order-1 bin context selector: control
// states, register indexes and the leading-one scanner status word.
// ----------------------------------------------------------------------------
package cbsel_pkg;

   // register indexes on the csr port
   localparam logic [1:0] CSR_MODE = 2'd0;
   localparam logic [1:0] CSR_REST = 2'd1;
   localparam logic [1:0] CSR_EGK  = 2'd2;

   // binarization modes
   localparam logic MODE_TU  = 1'b0;
   localparam logic MODE_EGK = 1'b1;

   // reset value and legal range of the rest position register
   localparam logic [6:0] REST_RESET = 7'd10;
   localparam logic [6:0] REST_MIN   = 7'd1;
   localparam logic [6:0] REST_MAX   = 7'd64;

   // hard limit on indices per word
   localparam int OUT_LIMIT = 64;

   // leading-one scanner widths
   localparam int LEAD_WIDTH = 32;
   localparam int POS_WIDTH  = 5;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // scanner status seen by the sequencer
   typedef struct packed {
      logic                 done;
      logic [POS_WIDTH-1:0] pos;
   } lead_status_type;

endpackage

>>> rtl/core/cbsel_lead_one.sv
// ----------------------------------------------------------------------------
// cbsel_lead_one
// Iterative leading-one finder: shifts the value right one place a cycle
// until it is at most one, counting the shifts.
// ----------------------------------------------------------------------------
module cbsel_lead_one (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [cbsel_pkg::LEAD_WIDTH-1:0]    value,
   output cbsel_pkg::lead_status_type          status
);

   logic                                busy_ff, busy_in;
   logic [cbsel_pkg::LEAD_WIDTH-1:0]    value_ff, value_in;
   logic [cbsel_pkg::POS_WIDTH-1:0]     pos_ff, pos_in;
   logic                                above_one;

   // shared compare: value still above one
   assign above_one = |value_ff[cbsel_pkg::LEAD_WIDTH-1:1];

   // shift and count step
   always_comb begin
      busy_in  = busy_ff;
      value_in = value_ff;
      pos_in   = pos_ff;
      if (start) begin
         busy_in  = 1'b1;
         value_in = value;
         pos_in   = '0;
      end else if (busy_ff) begin
         if (above_one) begin
            value_in = value_ff >> 1;
            pos_in   = pos_ff + 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      value_ff <= value_in;
      pos_ff   <= pos_in;
   end

   assign status.done = busy_ff && !above_one;
   assign status.pos  = pos_ff;

   // shift count never passes the top bit position
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff && above_one |-> pos_ff != '1)
      else $error("leading-one count overflow");

   // a new start only arrives while the scanner is idle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("scanner restarted while busy");

   // finishing drops busy on the next cycle
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      status.done && !start |=> !busy_ff)
      else $error("scanner stayed busy after done");

endmodule

>>> rtl/core/cbsel_ctx_unit.sv
// ----------------------------------------------------------------------------
// cbsel_ctx_unit
// Context index for one bin position from the reference length and the
// number of individually modelled positions.
// ----------------------------------------------------------------------------
module cbsel_ctx_unit (
   input  logic [6:0]  bin_pos,
   input  logic [30:0] ref_len,
   input  logic [6:0]  rest_pos,
   output logic [7:0]  ctx_id
);

   logic [30:0] pos_wide;
   logic [7:0]  rest_x1;
   logic [7:0]  rest_x2;
   logic [7:0]  rest_x3;

   assign pos_wide = {24'd0, bin_pos};
   assign rest_x1  = {1'b0, rest_pos};
   assign rest_x2  = {rest_pos, 1'b0};
   assign rest_x3  = rest_x2 + rest_x1;

   // rest context, then above, below or equal to the reference length
   always_comb begin
      if (bin_pos >= rest_pos) begin
         ctx_id = rest_x3;
      end else if (pos_wide > ref_len) begin
         ctx_id = {1'b0, bin_pos};
      end else if (pos_wide < ref_len) begin
         ctx_id = rest_x1 + {1'b0, bin_pos};
      end else begin
         ctx_id = rest_x2 + {1'b0, bin_pos};
      end
   end

endmodule

>>> rtl/core/cabac_bin_order1_context_select.sv
// ----------------------------------------------------------------------------
// cabac_bin_order1_context_select
// Emits one context index per bin position for each request word, with the
// reference length taken from the previous symbol (TU or EGk prefix).
//
//   channel | dir | handshake          | payload
//   req     | in  | req_valid/stall    | symbol_prev[30:0], bin_count[6:0]
//   rsp     | out | rsp_valid/stall    | ctx_id[7:0], bin_index[5:0], last_bin
//   csr     | in  | csr_valid/ready    | csr_index[1:0], csr_data[6:0]
//
// An EGk word first passes through the leading-one scanner, which shifts one
// bit a cycle. Emission is one index a cycle through the output register
// while rsp_stall is low. Reset is synchronous; csr_ready is always high.
// rsp_stall holds the output register and pauses emission; req_stall is
// high while a word is being scanned or emitted.
// ----------------------------------------------------------------------------
module cabac_bin_order1_context_select #(
   parameter int MAX_BINS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [30:0] req_symbol_prev,
   input  logic [6:0]  req_bin_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_ctx_id,
   output logic [5:0]  rsp_bin_index,
   output logic        rsp_last_bin,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data
);

   localparam int CAP = (MAX_BINS < cbsel_pkg::OUT_LIMIT) ? MAX_BINS : cbsel_pkg::OUT_LIMIT;
   localparam logic [6:0] CAP_W = 7'(CAP);

   cbsel_pkg::state_type  state_ff, state_in;
   logic                  mode_ff, mode_in;
   logic [6:0]            rest_ff, rest_in;
   logic [4:0]            egk_ff, egk_in;
   logic [6:0]            count_ff, count_in;
   logic [6:0]            pos_ff, pos_in;
   logic [30:0]           ref_ff, ref_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            ctx_ff, ctx_in;
   logic [5:0]            index_ff, index_in;
   logic                  last_ff, last_in;

   logic                  req_take;
   logic                  out_free;
   logic [6:0]            count_sat;
   logic                  scan_start;
   logic [cbsel_pkg::LEAD_WIDTH-1:0] scan_value;
   cbsel_pkg::lead_status_type       scan_status;
   logic [7:0]            ctx_sel;
   logic                  is_last;
   logic [4:0]            len_egk;

   assign req_stall = (state_ff != cbsel_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !valid_ff || !rsp_stall;
   assign count_sat = (req_bin_count > CAP_W) ? CAP_W : req_bin_count;
   assign csr_ready = 1'b1;

   // egk sum for the scanner
   assign scan_value = {1'b0, req_symbol_prev} + (32'd1 << egk_ff);
   assign scan_start = req_take && (mode_ff == cbsel_pkg::MODE_EGK);
   assign len_egk    = scan_status.pos - egk_ff;
   assign is_last    = (pos_ff + 7'd1) == count_ff;

   cbsel_lead_one u_lead_one (
      .clock  (clock),
      .reset  (reset),
      .start  (scan_start),
      .value  (scan_value),
      .status (scan_status)
   );

   cbsel_ctx_unit u_ctx_unit (
      .bin_pos  (pos_ff),
      .ref_len  (ref_ff),
      .rest_pos (rest_ff),
      .ctx_id   (ctx_sel)
   );

   // configuration registers
   always_comb begin
      mode_in = mode_ff;
      rest_in = rest_ff;
      egk_in  = egk_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cbsel_pkg::CSR_MODE: mode_in = csr_data[0];
            cbsel_pkg::CSR_REST: begin
               if (csr_data < cbsel_pkg::REST_MIN) begin
                  rest_in = cbsel_pkg::REST_MIN;
               end else if (csr_data > cbsel_pkg::REST_MAX) begin
                  rest_in = cbsel_pkg::REST_MAX;
               end else begin
                  rest_in = csr_data;
               end
            end
            cbsel_pkg::CSR_EGK: egk_in = csr_data[4:0];
            default: ;
         endcase
      end
   end

   // sequencer and output word
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      ref_in   = ref_ff;
      valid_in = valid_ff && rsp_stall;
      ctx_in   = ctx_ff;
      index_in = index_ff;
      last_in  = last_ff;
      unique case (state_ff)
         cbsel_pkg::ST_IDLE: begin
            if (req_take) begin
               count_in = count_sat;
               pos_in   = '0;
               if (mode_ff == cbsel_pkg::MODE_EGK) begin
                  state_in = cbsel_pkg::ST_SCAN;
               end else begin
                  ref_in = req_symbol_prev;
                  if (count_sat != 7'd0) begin
                     state_in = cbsel_pkg::ST_EMIT;
                  end
               end
            end
         end
         cbsel_pkg::ST_SCAN: begin
            if (scan_status.done) begin
               ref_in = {26'd0, len_egk};
               if (count_ff != 7'd0) begin
                  state_in = cbsel_pkg::ST_EMIT;
               end else begin
                  state_in = cbsel_pkg::ST_IDLE;
               end
            end
         end
         cbsel_pkg::ST_EMIT: begin
            if (out_free) begin
               valid_in = 1'b1;
               ctx_in   = ctx_sel;
               index_in = pos_ff[5:0];
               last_in  = is_last;
               pos_in   = pos_ff + 7'd1;
               if (is_last) begin
                  state_in = cbsel_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = cbsel_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbsel_pkg::ST_IDLE;
         valid_ff <= 1'b0;
         mode_ff  <= cbsel_pkg::MODE_TU;
         rest_ff  <= cbsel_pkg::REST_RESET;
         egk_ff   <= '0;
         count_ff <= '0;
         pos_ff   <= '0;
         ref_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         mode_ff  <= mode_in;
         rest_ff  <= rest_in;
         egk_ff   <= egk_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         ref_ff   <= ref_in;
      end
      ctx_ff   <= ctx_in;
      index_ff <= index_in;
      last_ff  <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_ctx_id    = ctx_ff;
   assign rsp_bin_index = index_ff;
   assign rsp_last_bin  = last_ff;

   // rest position register stays inside its legal range
   a_rest_range: assert property (@(posedge clock) disable iff (reset)
      rest_ff >= cbsel_pkg::REST_MIN && rest_ff <= cbsel_pkg::REST_MAX)
      else $error("rest positions out of range");

   // emission never runs past the word's count
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == cbsel_pkg::ST_EMIT |-> pos_ff < count_ff)
      else $error("bin position past count");

   // scanner reports only while the sequencer waits on it
   a_scan_owner: assert property (@(posedge clock) disable iff (reset)
      scan_status.done |-> state_ff == cbsel_pkg::ST_SCAN)
      else $error("scanner done outside scan state");

   // an emitted context index stays within three rest ranges
   a_ctx_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ctx_ff <= 8'd192)
      else $error("context index out of range");

   // a tu word with no bins leaves the block idle
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      req_take && mode_ff == cbsel_pkg::MODE_TU && count_sat == 7'd0 |=> !req_stall)
      else $error("empty word did not return to idle");

endmodule
